[hw/rtl/abd_pkg.sv]
// Shared types, constants and tables for the ADPCM block decoder.
// No dependencies; used by the core, the multiplier and the top level.
package abd_pkg;

  localparam int MAX_CHANNELS_DEF = 2;

  localparam int DW     = 56;   // adaptive delta width, holds 3x the adapt limit
  localparam int MAC_AW = 57;
  localparam int MAC_BW = 11;
  localparam int MAC_PW = 68;

  localparam int S16_MIN = -32768;
  localparam int S16_MAX = 32767;
  localparam int IMA_IDX_MAX = 88;
  localparam int MS_DELTA_MIN = 16;
  localparam int MS_PRED_MAX = 6;

  localparam logic [DW-1:0] DELTA_LIMIT = DW'(64'h7FFF_FFFF_FFFF_FFFF / 768);

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_FORMAT   = 3'd1;
  localparam logic [2:0] ERR_GEOMETRY = 3'd2;
  localparam logic [2:0] ERR_SIZE     = 3'd3;
  localparam logic [2:0] ERR_IMA_HDR  = 3'd4;
  localparam logic [2:0] ERR_MS_HDR   = 3'd5;

  localparam logic [1:0] REG_MS_MODE  = 2'd0;
  localparam logic [1:0] REG_CHANNELS = 2'd1;
  localparam logic [1:0] REG_BLOCK    = 2'd2;
  localparam logic [1:0] REG_FRAMES   = 2'd3;

  typedef enum logic [1:0] {MAC_HOLD, MAC_LOAD, MAC_ADD} mac_op_t;

  typedef struct packed {
    logic        ms;
    logic        ch2;
    logic [3:0]  hdr;
    logic [15:0] bs;
    logic [2:0]  err;
  } cfg_t;

  localparam logic [14:0] STEP_TAB [89] = '{
    15'd7, 15'd8, 15'd9, 15'd10, 15'd11, 15'd12, 15'd13, 15'd14, 15'd16, 15'd17,
    15'd19, 15'd21, 15'd23, 15'd25, 15'd28, 15'd31, 15'd34, 15'd37, 15'd41, 15'd45,
    15'd50, 15'd55, 15'd60, 15'd66, 15'd73, 15'd80, 15'd88, 15'd97, 15'd107, 15'd118,
    15'd130, 15'd143, 15'd157, 15'd173, 15'd190, 15'd209, 15'd230, 15'd253, 15'd279,
    15'd307, 15'd337, 15'd371, 15'd408, 15'd449, 15'd494, 15'd544, 15'd598, 15'd658,
    15'd724, 15'd796, 15'd876, 15'd963, 15'd1060, 15'd1166, 15'd1282, 15'd1411,
    15'd1552, 15'd1707, 15'd1878, 15'd2066, 15'd2272, 15'd2499, 15'd2749, 15'd3024,
    15'd3327, 15'd3660, 15'd4026, 15'd4428, 15'd4871, 15'd5358, 15'd5894, 15'd6484,
    15'd7132, 15'd7845, 15'd8630, 15'd9493, 15'd10442, 15'd11487, 15'd12635,
    15'd13899, 15'd15289, 15'd16818, 15'd18500, 15'd20350, 15'd22385, 15'd24623,
    15'd27086, 15'd29794, 15'd32767};

  localparam logic signed [4:0] IDX_ADJ [8] = '{
    -5'sd1, -5'sd1, -5'sd1, -5'sd1, 5'sd2, 5'sd4, 5'sd6, 5'sd8};

  localparam logic [9:0] ADAPT_TAB [16] = '{
    10'd230, 10'd230, 10'd230, 10'd230, 10'd307, 10'd409, 10'd512, 10'd614,
    10'd768, 10'd614, 10'd512, 10'd409, 10'd307, 10'd230, 10'd230, 10'd230};

  localparam logic signed [10:0] COEF0 [7] = '{
    11'sd256, 11'sd512, 11'sd0, 11'sd192, 11'sd240, 11'sd460, 11'sd392};
  localparam logic signed [10:0] COEF1 [7] = '{
    11'sd0, -11'sd256, 11'sd0, 11'sd64, 11'sd0, -11'sd208, -11'sd232};

endpackage

[hw/rtl/abd_if.sv]
// Valid/ready stream interfaces for encoded bytes in and decoded results out.
// Depends on nothing but the payload widths of the block.
interface abd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_block;
  modport source (output valid, data_byte, end_of_block, input ready);
  modport sink (input valid, data_byte, end_of_block, output ready);
endinterface

interface abd_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic [16:0]        frame_index;
  logic               channel;
  logic               sample_valid;
  logic [2:0]         error_code;
  logic               last_of_run;
  modport source (output valid, sample, frame_index, channel, sample_valid, error_code,
                  last_of_run, input ready);
  modport sink (input valid, sample, frame_index, channel, sample_valid, error_code,
                last_of_run, output ready);
endinterface

[hw/rtl/abd_mac.sv]
// Shared signed multiply-accumulate unit with a registered accumulator.
// Depends on abd_pkg for widths and the operation code.
module abd_mac (
  input  logic                               clk,
  input  abd_pkg::mac_op_t                   op,
  input  logic signed [abd_pkg::MAC_AW-1:0]  a,
  input  logic signed [abd_pkg::MAC_BW-1:0]  b,
  output logic signed [abd_pkg::MAC_PW-1:0]  acc
);

  logic signed [abd_pkg::MAC_PW-1:0] prod;

  assign prod = a * b;

  always_ff @(posedge clk) begin
    unique case (op)
      abd_pkg::MAC_LOAD: acc <= prod;
      abd_pkg::MAC_ADD:  acc <= acc + prod;
      default:           acc <= acc;
    endcase
  end

endmodule

[hw/rtl/abd_core.sv]
// Byte sequencer: header parsing, per-channel predictor state, nibble decode, result register.
// Depends on abd_pkg, abd_if and abd_mac.
module abd_core #(
  parameter int MAX_CHANNELS = abd_pkg::MAX_CHANNELS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  abd_pkg::cfg_t cfg,
  abd_in_if.sink        stream,
  abd_out_if.source     result
);

  localparam int PW = abd_pkg::MAC_PW;
  localparam int DW = abd_pkg::DW;
  localparam logic signed [PW-1:0] LO = PW'(abd_pkg::S16_MIN);
  localparam logic signed [PW-1:0] HI = PW'(abd_pkg::S16_MAX);

  typedef enum logic [3:0] {
    S_IDLE, S_HDR, S_IMA, S_M0, S_M1, S_M2, S_M3, S_M4, S_ERR
  } state_t;

  function automatic logic signed [15:0] clip16(input logic signed [PW-1:0] v);
    if (v < LO) clip16 = 16'sh8000;
    else if (v > HI) clip16 = 16'sh7FFF;
    else clip16 = v[15:0];
  endfunction

  state_t state;
  logic [16:0] pos;
  logic [7:0]  hlb;
  logic        failed;
  logic [7:0]  b_r;
  logic        eob_r;
  logic [16:0] d_r;
  logic        k;
  logic [1:0]  e;
  logic [2:0]  err_r;
  logic signed [17:0] pred_r;

  logic signed [15:0] cur [MAX_CHANNELS];
  logic signed [15:0] prev [MAX_CHANNELS];
  logic [6:0]         sidx [MAX_CHANNELS];
  logic [2:0]         pred_sel [MAX_CHANNELS];
  logic [DW-1:0]      delta [MAX_CHANNELS];

  // request path
  logic accept;
  logic [3:0] nch;
  logic hdr_phase, hdr_end, size_bad;
  logic [3:0] q;
  logic [1:0] seg;
  logic [15:0] w;
  logic [2:0] hdr_err, acc_err;

  assign stream.ready = (state == S_IDLE);
  assign accept = stream.valid && stream.ready;
  assign nch = cfg.ch2 ? 4'd2 : 4'd1;
  assign hdr_phase = pos < {13'd0, cfg.hdr};
  assign hdr_end = (pos + 17'd1) == {13'd0, cfg.hdr};
  assign size_bad = (pos >= {1'b0, cfg.bs}) ||
                    (stream.end_of_block && ((pos + 17'd1) != {1'b0, cfg.bs}));
  assign q = pos[3:0] - nch;
  assign seg = cfg.ch2 ? q[3:2] : q[2:1];
  assign w = {stream.data_byte, hlb};

  always_comb begin
    hdr_err = abd_pkg::ERR_NONE;
    if (!cfg.ms) begin
      if (pos[1:0] == 2'd2 && stream.data_byte > 8'(abd_pkg::IMA_IDX_MAX))
        hdr_err = abd_pkg::ERR_IMA_HDR;
      else if (pos[1:0] == 2'd3 && stream.data_byte != 8'd0)
        hdr_err = abd_pkg::ERR_IMA_HDR;
    end else if (pos < {13'd0, nch}) begin
      if (stream.data_byte > 8'(abd_pkg::MS_PRED_MAX)) hdr_err = abd_pkg::ERR_MS_HDR;
    end else if (q[0] && seg == 2'd0 && w < 16'(abd_pkg::MS_DELTA_MIN)) begin
      hdr_err = abd_pkg::ERR_MS_HDR;
    end
  end

  always_comb begin
    if (cfg.err != abd_pkg::ERR_NONE) acc_err = cfg.err;
    else if (size_bad) acc_err = abd_pkg::ERR_SIZE;
    else if (hdr_phase) acc_err = hdr_err;
    else acc_err = abd_pkg::ERR_NONE;
  end

  // channel selected by the running step
  logic cidx;
  always_comb begin
    if (state == S_HDR) cidx = cfg.ms ? e[1] : e[0];
    else if (cfg.ms) cidx = cfg.ch2 & k;
    else cidx = cfg.ch2 & d_r[2];
  end

  logic signed [15:0] cur_c, prev_c;
  logic [6:0]         sidx_c;
  logic [2:0]         p_c;
  logic [DW-1:0]      delta_c;
  assign cur_c = cur[cidx];
  assign prev_c = prev[cidx];
  assign sidx_c = (sidx[cidx] > 7'(abd_pkg::IMA_IDX_MAX)) ? 7'(abd_pkg::IMA_IDX_MAX) : sidx[cidx];
  assign p_c = (pred_sel[cidx] > 3'(abd_pkg::MS_PRED_MAX)) ? 3'(abd_pkg::MS_PRED_MAX)
                                                         : pred_sel[cidx];
  assign delta_c = delta[cidx];

  // IMA nibble
  logic [3:0]  ima_nib;
  logic [14:0] step;
  logic [16:0] diff;
  logic signed [17:0] ima_base, ima_sum;
  logic signed [15:0] ima_new;
  logic signed [7:0]  idx_t;
  logic [6:0]  idx_new;
  logic [17:0] ima_s0;
  logic [16:0] ima_frame;

  assign ima_nib = k ? b_r[7:4] : b_r[3:0];
  assign step = abd_pkg::STEP_TAB[sidx_c];
  assign diff = 17'(step >> 3) + (ima_nib[0] ? 17'(step >> 2) : 17'd0) +
                (ima_nib[1] ? 17'(step >> 1) : 17'd0) + (ima_nib[2] ? 17'(step) : 17'd0);
  assign ima_base = 18'(cur_c);
  assign ima_sum = ima_nib[3] ? ima_base - $signed({1'b0, diff})
                              : ima_base + $signed({1'b0, diff});
  assign ima_new = clip16(PW'(ima_sum));
  assign idx_t = $signed({1'b0, sidx_c}) + 8'(abd_pkg::IDX_ADJ[ima_nib[2:0]]);
  assign idx_new = (idx_t < 8'sd0) ? 7'd0 :
                   (idx_t > 8'(abd_pkg::IMA_IDX_MAX)) ? 7'(abd_pkg::IMA_IDX_MAX) : idx_t[6:0];
  assign ima_s0 = cfg.ch2 ? {1'b0, d_r[16:3], 3'b000} + 18'({d_r[1:0], 1'b0})
                          : {d_r, 1'b0};
  assign ima_frame = 17'(ima_s0 + 18'(k) + 18'd1);

  // Microsoft nibble
  abd_pkg::mac_op_t mac_op;
  logic signed [abd_pkg::MAC_AW-1:0] mac_a;
  logic signed [abd_pkg::MAC_BW-1:0] mac_b;
  logic signed [PW-1:0] acc, acc_rnd, acc_sh, ms_sum;
  logic [3:0]  ms_nib;
  logic signed [15:0] ms_new;
  logic        ovf;
  logic [16:0] ms_frame;

  abd_mac u_mac (.clk(clk), .op(mac_op), .a(mac_a), .b(mac_b), .acc(acc));

  assign ms_nib = k ? b_r[3:0] : b_r[7:4];
  // divide by 256 toward zero
  assign acc_rnd = acc + (acc[PW-1] ? PW'(255) : PW'(0));
  assign acc_sh = acc >>> 8;
  assign ms_sum = acc + PW'(pred_r);
  assign ms_new = clip16(ms_sum);
  assign ovf = delta_c > abd_pkg::DELTA_LIMIT;
  assign ms_frame = 17'(cfg.ch2 ? {1'b0, d_r} + 18'd2 : {d_r, 1'b0} + 18'(k) + 18'd2);

  // result register
  logic can_put, put, p_chan, p_valid, p_last;
  logic signed [15:0] p_sample;
  logic [16:0] p_frame;
  logic [2:0]  p_err;
  logic [1:0]  last_e;

  assign can_put = !result.valid || result.ready;
  assign last_e = cfg.ms ? (cfg.ch2 ? 2'd3 : 2'd1) : (cfg.ch2 ? 2'd1 : 2'd0);

  always_comb begin
    put = 1'b0;
    p_sample = '0;
    p_frame = '0;
    p_chan = 1'b0;
    p_valid = 1'b0;
    p_err = abd_pkg::ERR_NONE;
    p_last = 1'b0;
    mac_op = abd_pkg::MAC_HOLD;
    mac_a = '0;
    mac_b = '0;
    unique case (state)
      S_HDR: begin
        put = can_put;
        p_sample = (cfg.ms && !e[0]) ? prev_c : cur_c;
        p_frame = 17'(cfg.ms & e[0]);
        p_chan = cidx;
        p_valid = 1'b1;
        p_last = (e == last_e);
      end
      S_ERR: begin
        put = can_put;
        p_err = err_r;
        p_last = 1'b1;
      end
      S_IMA: begin
        put = can_put;
        p_sample = ima_new;
        p_frame = ima_frame;
        p_chan = cidx;
        p_valid = 1'b1;
        p_last = k;
      end
      S_M0: begin
        mac_op = abd_pkg::MAC_LOAD;
        mac_a = abd_pkg::MAC_AW'(cur_c);
        mac_b = abd_pkg::COEF0[p_c];
      end
      S_M1: begin
        mac_op = abd_pkg::MAC_ADD;
        mac_a = abd_pkg::MAC_AW'(prev_c);
        mac_b = abd_pkg::COEF1[p_c];
      end
      S_M2: begin
        mac_op = abd_pkg::MAC_LOAD;
        mac_a = $signed({1'b0, delta_c});
        mac_b = abd_pkg::MAC_BW'($signed(ms_nib));
      end
      S_M3: begin
        put = can_put;
        if (ovf) begin
          p_err = abd_pkg::ERR_MS_HDR;
          p_last = 1'b1;
        end else begin
          p_sample = ms_new;
          p_frame = ms_frame;
          p_chan = cidx;
          p_valid = 1'b1;
          p_last = k;
          if (can_put) mac_op = abd_pkg::MAC_LOAD;
          mac_a = $signed({1'b0, delta_c});
          mac_b = $signed({1'b0, abd_pkg::ADAPT_TAB[ms_nib]});
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pos <= '0;
      hlb <= '0;
      failed <= 1'b0;
      result.valid <= 1'b0;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        cur[i] <= '0;
        prev[i] <= '0;
        sidx[i] <= '0;
        pred_sel[i] <= '0;
        delta[i] <= '0;
      end
    end else begin
      if (put) begin
        result.valid <= 1'b1;
        result.sample <= p_sample;
        result.frame_index <= p_frame;
        result.channel <= p_chan;
        result.sample_valid <= p_valid;
        result.error_code <= p_err;
        result.last_of_run <= p_last;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            b_r <= stream.data_byte;
            eob_r <= stream.end_of_block;
            if (failed) begin
              // drop bytes until the block ends
              if (stream.end_of_block) begin
                pos <= '0;
                failed <= 1'b0;
              end
            end else begin
              pos <= stream.end_of_block ? 17'd0 : pos + 17'd1;
              if (acc_err != abd_pkg::ERR_NONE) begin
                err_r <= acc_err;
                failed <= !stream.end_of_block;
                state <= S_ERR;
              end else if (hdr_phase) begin
                if (!cfg.ms) begin
                  unique case (pos[1:0])
                    2'd0: hlb <= stream.data_byte;
                    2'd1: cur[pos[2]] <= w;
                    2'd2: sidx[pos[2]] <= stream.data_byte[6:0];
                    default: ;
                  endcase
                end else if (pos < {13'd0, nch}) begin
                  pred_sel[pos[0]] <= stream.data_byte[2:0];
                end else if (!q[0]) begin
                  hlb <= stream.data_byte;
                end else begin
                  unique case (seg)
                    2'd0: delta[cfg.ch2 & q[1]] <= DW'(w);
                    2'd1: cur[cfg.ch2 & q[1]] <= w;
                    default: prev[cfg.ch2 & q[1]] <= w;
                  endcase
                end
                if (hdr_end) begin
                  e <= '0;
                  state <= S_HDR;
                end
              end else begin
                d_r <= pos - {13'd0, cfg.hdr};
                k <= 1'b0;
                state <= cfg.ms ? S_M0 : S_IMA;
              end
            end
          end
        end
        S_HDR: begin
          if (can_put) begin
            e <= e + 2'd1;
            if (e == last_e) state <= S_IDLE;
          end
        end
        S_ERR: begin
          if (can_put) state <= S_IDLE;
        end
        S_IMA: begin
          if (can_put) begin
            cur[cidx] <= ima_new;
            sidx[cidx] <= idx_new;
            k <= 1'b1;
            if (k) state <= S_IDLE;
          end
        end
        S_M0: state <= S_M1;
        S_M1: state <= S_M2;
        S_M2: begin
          pred_r <= 18'(acc_rnd >>> 8);
          state <= S_M3;
        end
        S_M3: begin
          if (can_put) begin
            prev[cidx] <= cur_c;
            cur[cidx] <= ms_new;
            if (ovf) begin
              failed <= !eob_r;
              state <= S_IDLE;
            end else begin
              state <= S_M4;
            end
          end
        end
        S_M4: begin
          delta[cidx] <= (acc_sh < PW'(abd_pkg::MS_DELTA_MIN)) ? DW'(abd_pkg::MS_DELTA_MIN)
                                                               : DW'(acc_sh);
          k <= 1'b1;
          state <= k ? S_IDLE : S_M0;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[hw/rtl/adpcm_block_decoder.sv]
// ADPCM block decoder, IMA or Microsoft 4-bit, mono or stereo, one byte per request.
// IMA data byte: one result per nibble (nibble datapath); Microsoft: each nibble runs S_M0
// to S_M4 through the shared multiplier. Bytes are accepted only in idle; an error byte
// passes the error state, the last header byte the header state (one result per initial
// sample); output stalls hold the result states. Synchronous reset clears the registers to
// their defaults, the parser position, the failed flag and channel state.
module adpcm_block_decoder #(
  parameter int MAX_CHANNELS = abd_pkg::MAX_CHANNELS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  abd_in_if.sink      stream,
  abd_out_if.source   result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic        ms_mode;
  logic [1:0]  channel_count;
  logic [15:0] block_size_bytes;
  logic [17:0] frames_per_block;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ms_mode <= 1'b0;
      channel_count <= 2'd1;
      block_size_bytes <= 16'd256;
      frames_per_block <= 18'd505;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        abd_pkg::REG_MS_MODE:  ms_mode <= pwdata[0];
        abd_pkg::REG_CHANNELS: channel_count <= pwdata[1:0];
        abd_pkg::REG_BLOCK:    block_size_bytes <= pwdata[15:0];
        default:               frames_per_block <= pwdata[17:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      abd_pkg::REG_MS_MODE:  prdata = {31'd0, ms_mode};
      abd_pkg::REG_CHANNELS: prdata = {30'd0, channel_count};
      abd_pkg::REG_BLOCK:    prdata = {16'd0, block_size_bytes};
      default:               prdata = {14'd0, frames_per_block};
    endcase
  end

  // block geometry check
  abd_pkg::cfg_t cfg;
  logic        ch2;
  logic [3:0]  hdr;
  logic [15:0] body;
  logic [17:0] expect_frames;

  assign ch2 = (channel_count == 2'd2);
  assign hdr = ms_mode ? (ch2 ? 4'd14 : 4'd7) : (ch2 ? 4'd8 : 4'd4);
  assign body = block_size_bytes - {12'd0, hdr};
  assign expect_frames = (ms_mode ? 18'd2 : 18'd1) +
                         (ch2 ? {2'b00, body} : {1'b0, body, 1'b0});

  always_comb begin
    cfg.ms = ms_mode;
    cfg.ch2 = ch2;
    cfg.hdr = hdr;
    cfg.bs = block_size_bytes;
    if (channel_count == 2'd0 || 32'(channel_count) > MAX_CHANNELS)
      cfg.err = abd_pkg::ERR_FORMAT;
    else if (block_size_bytes < {12'd0, hdr})
      cfg.err = abd_pkg::ERR_GEOMETRY;
    else if (!ms_mode && ch2 && body[2:0] != 3'd0)
      cfg.err = abd_pkg::ERR_GEOMETRY;
    else if (frames_per_block != expect_frames)
      cfg.err = abd_pkg::ERR_GEOMETRY;
    else
      cfg.err = abd_pkg::ERR_NONE;
  end

  abd_core #(.MAX_CHANNELS(MAX_CHANNELS)) u_core (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .stream(stream),
    .result(result)
  );

endmodule
